/* hdl/truncated_binary_bit_packer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Truncated binary bit packer assertion macros
// Shared property shorthands for the checker of the packer unit.
// ----------------------------------------------------------------------------
`ifndef TRUNCATED_BINARY_BIT_PACKER_UNIT_MACROS_SVH
`define TRUNCATED_BINARY_BIT_PACKER_UNIT_MACROS_SVH

// same-cycle implication
`define TBP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TBP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/tbp_pkg.sv */
// ----------------------------------------------------------------------------
// Truncated binary bit packer package
// Field widths, action codes and the code word bundle shared by the unit.
// ----------------------------------------------------------------------------
package tbp_pkg;

   // request field widths
   localparam int ACTION_W = 2;
   localparam int VALUE_W  = 8;
   localparam int RANGE_W  = 9;

   // response field widths
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 4;

   // longest code word that is sent; never above nine bits
   localparam int MAX_CODE_BITS = 8;
   localparam int CODE_CAP      = (MAX_CODE_BITS < 9) ? MAX_CODE_BITS : 9;

   // code word and bit stream sizes
   localparam int WORD_W   = 9;
   localparam int LEN_W    = 4;
   localparam int STREAM_W = BYTE_W + WORD_W;
   localparam int TOTAL_W  = 5;

   // stream bus widths
   localparam int REQ_DATA_W = 24;
   localparam int REQ_USER_W = ACTION_W;
   localparam int RSP_DATA_W = 16;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_BIT   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CODE  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

   // one decoded request: bits to append, or a flush
   typedef struct packed {
      logic              flush;
      logic [LEN_W-1:0]  len;
      logic [WORD_W-1:0] word;
   } code_type;

endpackage

/* hdl/tbp_code.sv */
// ----------------------------------------------------------------------------
// Truncated binary code former
// Turns one request into a right-aligned code word and its length.
// ----------------------------------------------------------------------------
module tbp_code (
   input  logic [tbp_pkg::ACTION_W-1:0] action,
   input  logic                         bit_value,
   input  logic [tbp_pkg::VALUE_W-1:0]  value,
   input  logic [tbp_pkg::RANGE_W-1:0]  range_size,
   output tbp_pkg::code_type            code
);

   logic [tbp_pkg::RANGE_W-1:0]  m_eff;
   logic [tbp_pkg::RANGE_W-1:0]  m_less;
   logic [tbp_pkg::LEN_W-1:0]    k;
   logic [tbp_pkg::RANGE_W:0]    level;
   logic                         short_code;
   logic [tbp_pkg::RANGE_W:0]    sum;
   logic [tbp_pkg::LEN_W-1:0]    len_raw;
   logic [tbp_pkg::LEN_W-1:0]    len_cap;
   logic [tbp_pkg::WORD_W:0]     len_mask;
   logic [tbp_pkg::WORD_W-1:0]   word_raw;

   // k = bit length of (m - 1), a range of zero counts as one
   always_comb begin
      m_eff  = (range_size == '0) ? tbp_pkg::RANGE_W'(1) : range_size;
      m_less = m_eff - tbp_pkg::RANGE_W'(1);
      k      = '0;
      for (int i = 0; i < tbp_pkg::RANGE_W; i++) begin
         if (m_less[i]) begin
            k = tbp_pkg::LEN_W'(i + 1);
         end
      end
   end

   // level, short or long code word
   always_comb begin
      level      = ({{tbp_pkg::RANGE_W{1'b0}}, 1'b1} << k) - {1'b0, m_eff};
      short_code = {{(tbp_pkg::RANGE_W + 1 - tbp_pkg::VALUE_W){1'b0}}, value} < level;
      sum        = {{(tbp_pkg::RANGE_W + 1 - tbp_pkg::VALUE_W){1'b0}}, value} + level;
      if (short_code) begin
         word_raw = {{(tbp_pkg::WORD_W - tbp_pkg::VALUE_W){1'b0}}, value};
         len_raw  = k - tbp_pkg::LEN_W'(1);
      end else begin
         word_raw = sum[tbp_pkg::WORD_W-1:0];
         len_raw  = k;
      end
      len_cap = (len_raw > tbp_pkg::LEN_W'(tbp_pkg::CODE_CAP)) ?
                tbp_pkg::LEN_W'(tbp_pkg::CODE_CAP) : len_raw;
      len_mask = ({{tbp_pkg::WORD_W{1'b0}}, 1'b1} << len_cap) -
                 {{tbp_pkg::WORD_W{1'b0}}, 1'b1};
   end

   // per-action selection
   always_comb begin
      code = '0;
      case (action)
         tbp_pkg::ACT_BIT: begin
            code.len  = tbp_pkg::LEN_W'(1);
            code.word = {{(tbp_pkg::WORD_W - 1){1'b0}}, bit_value};
         end
         tbp_pkg::ACT_CODE: begin
            code.len  = len_cap;
            code.word = word_raw & len_mask[tbp_pkg::WORD_W-1:0];
         end
         tbp_pkg::ACT_FLUSH: begin
            code.flush = 1'b1;
         end
         default: begin
            code = '0;
         end
      endcase
   end

endmodule

/* hdl/tbp_pack.sv */
// ----------------------------------------------------------------------------
// Truncated binary bit packer core
// Holds the pending bits; merges one code word into them per cycle with fire set.
// ----------------------------------------------------------------------------
module tbp_pack (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  tbp_pkg::code_type           code,
   output logic                        emit,
   output logic [tbp_pkg::BYTE_W-1:0]  out_byte,
   output logic [tbp_pkg::COUNT_W-1:0] bit_count
);

   logic [tbp_pkg::BYTE_W-1:0]   pending_bits_ff, pending_bits_in;
   logic [tbp_pkg::COUNT_W-1:0]  pending_count_ff, pending_count_in;

   logic [tbp_pkg::STREAM_W-1:0] stream;
   logic [tbp_pkg::STREAM_W-1:0] stream_hi;
   logic [tbp_pkg::TOTAL_W-1:0]  total;
   logic [tbp_pkg::TOTAL_W-1:0]  total_less;
   logic [tbp_pkg::COUNT_W-1:0]  fill;
   logic [tbp_pkg::BYTE_W:0]     keep_mask;

   // pending bits followed by the code word, oldest bit highest
   always_comb begin
      stream     = (tbp_pkg::STREAM_W'(pending_bits_ff) << code.len) |
                   tbp_pkg::STREAM_W'(code.word);
      total      = tbp_pkg::TOTAL_W'(pending_count_ff) + tbp_pkg::TOTAL_W'(code.len);
      total_less = total - tbp_pkg::TOTAL_W'(1);
      // bits left pending: 1..8, a full byte stays until the next bit or a flush
      fill       = {1'b0, total_less[2:0]} + tbp_pkg::COUNT_W'(1);
      keep_mask  = ({{tbp_pkg::BYTE_W{1'b0}}, 1'b1} << fill) -
                   {{tbp_pkg::BYTE_W{1'b0}}, 1'b1};
      stream_hi  = stream >> fill;
   end

   // result and next state
   always_comb begin
      emit             = 1'b0;
      out_byte         = stream_hi[tbp_pkg::BYTE_W-1:0];
      bit_count        = tbp_pkg::COUNT_W'(tbp_pkg::BYTE_W);
      pending_bits_in  = pending_bits_ff;
      pending_count_in = pending_count_ff;
      if (code.flush) begin
         emit             = 1'b1;
         out_byte         = pending_bits_ff;
         bit_count        = pending_count_ff;
         pending_bits_in  = '0;
         pending_count_in = '0;
      end else if (code.len != '0) begin
         // last byte pushed out, if the stream ran past one byte
         emit             = total > tbp_pkg::TOTAL_W'(tbp_pkg::BYTE_W);
         pending_bits_in  = stream[tbp_pkg::BYTE_W-1:0] & keep_mask[tbp_pkg::BYTE_W-1:0];
         pending_count_in = fill;
      end
   end

   // pending state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_bits_ff  <= '0;
         pending_count_ff <= '0;
      end else if (fire) begin
         pending_bits_ff  <= pending_bits_in;
         pending_count_ff <= pending_count_in;
      end
   end

endmodule

/* hdl/truncated_binary_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// Truncated binary bit packer unit
// Packs single bits and truncated binary code words MSB-first into bytes.
// A request is taken every cycle as long as it emits no byte. A request that
// emits a byte, such as a flush or a code that overflows the pending byte,
// moves on only when the output register is empty or being read. While a
// response stalls, it waits in the input register and holds off req_tready.
// Each request sits in the input register, where its code word is
// formed and merged into the pending byte. Its response is loaded into the
// output register as the request leaves the input register, and rsp_tvalid
// rises with it. The rate is set by the loop through the pending byte
// register. A full byte leaves only when a further bit arrives or on a
// flush; flush returns the pending bits right-aligned with their count, even
// when that count is zero.
// ----------------------------------------------------------------------------
module truncated_binary_bit_packer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // bit_value[0], value[8:1], range_size[17:9], zero pad[23:18]
   input  logic [tbp_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [tbp_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_byte[7:0], bit_count[11:8], zero pad[15:12]
   output logic [tbp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic                           in_valid_ff, in_valid_in;
   logic [tbp_pkg::ACTION_W-1:0]   action_ff;
   logic                           bit_value_ff;
   logic [tbp_pkg::VALUE_W-1:0]    value_ff;
   logic [tbp_pkg::RANGE_W-1:0]    range_size_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [tbp_pkg::BYTE_W-1:0]     out_byte_ff;
   logic [tbp_pkg::COUNT_W-1:0]    bit_count_ff;

   tbp_pkg::code_type              code;
   logic                           emit;
   logic [tbp_pkg::BYTE_W-1:0]     out_byte;
   logic [tbp_pkg::COUNT_W-1:0]    bit_count;
   logic                           out_free;
   logic                           proceed;
   logic                           req_take;

   // handshake
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proceed    = in_valid_ff && (!emit || out_free);
   assign req_tready = !in_valid_ff || proceed;
   assign req_take   = req_tvalid && req_tready;

   // input register
   assign in_valid_in = req_take ? 1'b1 : (proceed ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         action_ff     <= req_tuser[tbp_pkg::ACTION_W-1:0];
         bit_value_ff  <= req_tdata[0];
         value_ff      <= req_tdata[tbp_pkg::VALUE_W:1];
         range_size_ff <= req_tdata[tbp_pkg::VALUE_W+tbp_pkg::RANGE_W:tbp_pkg::VALUE_W+1];
      end
   end

   // code word forming
   tbp_code u_code (
      .action     (action_ff),
      .bit_value  (bit_value_ff),
      .value      (value_ff),
      .range_size (range_size_ff),
      .code       (code)
   );

   // packing
   tbp_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .fire      (proceed),
      .code      (code),
      .emit      (emit),
      .out_byte  (out_byte),
      .bit_count (bit_count)
   );

   // output register
   always_comb begin
      if (proceed && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (proceed && emit) begin
         out_byte_ff  <= out_byte;
         bit_count_ff <= bit_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(tbp_pkg::RSP_DATA_W - tbp_pkg::BYTE_W - tbp_pkg::COUNT_W){1'b0}},
                        bit_count_ff, out_byte_ff};

endmodule

/* hdl/tbp_checker.sv */
// ----------------------------------------------------------------------------
// Truncated binary bit packer checker
// Port-level properties of the packer unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "truncated_binary_bit_packer_unit_macros.svh"

module tbp_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [tbp_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled response holds
   `TBP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "response changed while stalled")

   // bit count within a byte, pad bits clear
   `TBP_ASSERT_SAME(a_rsp_count, clock, reset, rsp_tvalid, rsp_tdata[11:8] <= 4'd8 && rsp_tdata[15:12] == 4'd0, "bad bit count or pad")

   // a response after an empty output comes from a request that passed the input register with no stall
   `TBP_ASSERT_SAME(a_rsp_origin, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready, 2), "response without a request")

   // reset leaves the unit empty and ready
   `TBP_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && req_tready, "unit not empty after reset")

endmodule

bind truncated_binary_bit_packer_unit tbp_checker u_tbp_checker (.*);
